// ----- sv/i2c_tsr_pkg.sv -----
// Package: pin program table, segment codes and reading formatter for the sensor reader.
`timescale 1ns / 1ps
`default_nettype none
package i2c_tsr_pkg;

	// Segment kinds of the pin program
	typedef logic [2:0] seg_kind_t;
	localparam seg_kind_t SEG_START = 3'd0;
	localparam seg_kind_t SEG_STOP  = 3'd1;
	localparam seg_kind_t SEG_ACK   = 3'd2;
	localparam seg_kind_t SEG_NACK  = 3'd3;
	localparam seg_kind_t SEG_SEND  = 3'd4;
	localparam seg_kind_t SEG_READ  = 3'd5;

	// Byte selectors for send segments
	typedef logic [1:0] byte_sel_t;
	localparam byte_sel_t BYTE_ADDR_WR = 2'd0;
	localparam byte_sel_t BYTE_ADDR_RD = 2'd1;
	localparam byte_sel_t BYTE_CONVERT = 2'd2;
	localparam byte_sel_t BYTE_FETCH   = 2'd3;

	typedef logic [4:0] step_t;
	typedef logic [4:0] sub_t;

	localparam step_t LAST_STEP = 5'd17;
	localparam step_t LOOP_STEP = 5'd6;

	localparam logic [7:0] ADDR_WR_BASE = 8'h90;
	localparam logic [7:0] ADDR_RD_BASE = 8'h91;
	localparam logic [7:0] CMD_CONVERT  = 8'hEE;
	localparam logic [7:0] CMD_FETCH    = 8'hAA;
	localparam logic [7:0] MOST_NEG     = 8'h80;

	localparam logic [5:0] CHAR_PLUS  = 6'd43;
	localparam logic [5:0] CHAR_MINUS = 6'd45;
	localparam logic [5:0] CHAR_ZERO  = 6'd48;

	// Register index of the configuration port
	localparam logic REG_SENSOR_ADDRESS = 1'b0;

	typedef struct packed {
		logic       valid;
		logic [5:0] sign;
		logic [5:0] hund;
		logic [5:0] tens;
		logic [5:0] units;
	} shown_t;

	function automatic seg_kind_t seg_kind(input step_t step);
		seg_kind_t k;
		case (step)
			5'd0, 5'd6, 5'd12: k = SEG_START;
			5'd1, 5'd3, 5'd7, 5'd9, 5'd13: k = SEG_SEND;
			5'd2, 5'd8, 5'd14: k = SEG_ACK;
			5'd4, 5'd10, 5'd16: k = SEG_NACK;
			5'd15: k = SEG_READ;
			default: k = SEG_STOP;
		endcase
		return k;
	endfunction

	function automatic byte_sel_t seg_arg(input step_t step);
		byte_sel_t a;
		case (step)
			5'd3: a = BYTE_CONVERT;
			5'd9: a = BYTE_FETCH;
			5'd13: a = BYTE_ADDR_RD;
			default: a = BYTE_ADDR_WR;
		endcase
		return a;
	endfunction

	// Index of the final sub-step of a segment
	function automatic sub_t seg_last(input seg_kind_t kind);
		sub_t l;
		case (kind)
			SEG_START, SEG_STOP: l = 5'd1;
			SEG_ACK, SEG_NACK:   l = 5'd2;
			SEG_SEND:            l = 5'd16;
			default:             l = 5'd15;
		endcase
		return l;
	endfunction

	// Sign and three digits; every code with the top bit set but the most negative one is negated
	function automatic shown_t format_reading(input logic [7:0] d);
		shown_t     s;
		logic       neg;
		logic [7:0] mag;
		logic       hund;
		logic [6:0] rem;
		logic [14:0] prod;
		logic [3:0] tens;
		logic [3:0] units;
		neg  = d[7] && (d != MOST_NEG);
		mag  = neg ? 8'(~d + 8'd1) : d;
		hund = (mag >= 8'd100);
		rem  = 7'(mag - (hund ? 8'd100 : 8'd0));
		// Divide by ten through the reciprocal 205/2048, exact below 1029
		prod = 15'(rem) * 15'd205;
		tens = prod[14:11];
		units = 4'(rem - 7'(tens) * 7'd10);
		s.valid = 1'b1;
		s.sign  = neg ? CHAR_MINUS : CHAR_PLUS;
		s.hund  = CHAR_ZERO + {5'd0, hund};
		s.tens  = CHAR_ZERO + {2'd0, tens};
		s.units = CHAR_ZERO + {2'd0, units};
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- sv/i2c_temp_sensor_reader_top.sv -----
// Top level: bit-banged two-wire temperature sensor reader with APB configuration.
//
// Usage: every beat on the slave stream is one tick carrying the sampled data
// line in s_tdata[0]. For each tick the block advances its pin program
// (each sub-step held for HOLD_TICKS ticks) and emits one beat on the master
// stream with the driven clock and data levels and the last reading shown as
// a sign character and three ASCII digits.
// After reset it sends a conversion start once, then loops on the read
// transaction; the shown reading updates at the final stop of each read.
// The result beat of an accepted tick is presented in the next cycle.
// Throughput: one tick per cycle while the receiver does not stall; the pin
// program state and the result register both update in the cycle of acceptance.
// The single output register decouples the sides: a new tick is taken
// whenever the register is empty or its beat is taken in the same cycle.
// When the receiver stalls, the result is held and ticks wait.
// Reset: lines released high, program at its first step, no reading shown,
// sensor_address cleared. The APB register sensor_address (address 0) is
// sampled when an address byte starts to be sent.
`timescale 1ns / 1ps
`default_nettype none
module i2c_temp_sensor_reader_top #(
	parameter int HOLD_TICKS = 1
) (
	input  wire         clk,
	input  wire         arst_n,
	// s_tdata: [0] sda_in, [7:1] zero
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,
	// m_tdata: [0] scl_level, [1] sda_level, [2] temp_valid, [8:3] sign_char,
	// [14:9] hundreds_char, [20:15] tens_char, [26:21] units_char, [31:27] zero
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import i2c_tsr_pkg::*;

	localparam int HW = (HOLD_TICKS > 1) ? $clog2(HOLD_TICKS) : 1;

	logic [2:0]    addr_q;
	step_t         step_q, step_n;
	sub_t          sub_q, sub_n;
	logic [HW-1:0] hold_q, hold_n;
	logic [7:0]    shift_q, shift_n;
	logic          scl_q, scl_n;
	logic          sda_q, sda_n;
	shown_t        shown_q, shown_n;
	logic          m_valid_q;
	logic [31:0]   m_data_q;
	seg_kind_t     kind;
	byte_sel_t     arg;
	logic          sda_in;
	logic          s_acc;

	// APB register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SENSOR_ADDRESS) ? {29'd0, addr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 3'd0;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_SENSOR_ADDRESS) begin
			addr_q <= pwdata[2:0];
		end
	end

	assign sda_in   = s_tdata[0];
	assign s_tready = !m_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	// Advance the pin program by one tick
	always_comb begin
		kind    = seg_kind(step_q);
		arg     = seg_arg(step_q);
		scl_n   = scl_q;
		sda_n   = sda_q;
		shift_n = shift_q;
		hold_n  = hold_q;
		sub_n   = sub_q;
		step_n  = step_q;
		shown_n = shown_q;
		if (hold_q == '0) begin
			case (kind)
				SEG_START: begin
					scl_n = 1'b1;
					sda_n = (sub_q == 5'd0);
				end
				SEG_STOP: begin
					scl_n = 1'b1;
					sda_n = (sub_q != 5'd0);
				end
				SEG_ACK, SEG_NACK: begin
					sda_n = (kind == SEG_NACK);
					if (sub_q == 5'd1) scl_n = 1'b1;
					else if (sub_q == 5'd2) scl_n = 1'b0;
				end
				SEG_SEND: begin
					if (sub_q == 5'd0) begin
						case (arg)
							BYTE_ADDR_WR: shift_n = ADDR_WR_BASE | {4'd0, addr_q, 1'b0};
							BYTE_ADDR_RD: shift_n = ADDR_RD_BASE | {4'd0, addr_q, 1'b0};
							BYTE_CONVERT: shift_n = CMD_CONVERT;
							default:      shift_n = CMD_FETCH;
						endcase
					end
					if (sub_q[4]) begin
						scl_n = 1'b0;
					end else begin
						sda_n = shift_n[7];
						scl_n = sub_q[0];
					end
				end
				default: begin
					if (sub_q == 5'd0) shift_n = 8'd0;
					sda_n = 1'b1;
					scl_n = sub_q[0];
				end
			endcase
		end
		// End of a held step: shift, then move on
		if (hold_q == HW'(HOLD_TICKS - 1)) begin
			hold_n = '0;
			if ((kind == SEG_SEND || kind == SEG_READ) && !sub_q[4] && sub_q[0]) begin
				shift_n = {shift_n[6:0], (kind == SEG_READ) ? sda_in : 1'b0};
			end
			if (sub_q == seg_last(kind)) begin
				sub_n = 5'd0;
				if (step_q == LAST_STEP) begin
					step_n  = LOOP_STEP;
					shown_n = format_reading(shift_n);
				end else begin
					step_n = step_q + 5'd1;
				end
			end else begin
				sub_n = sub_q + 5'd1;
			end
		end else begin
			hold_n = hold_q + HW'(1);
		end
	end

	// Program state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 5'd0;
			sub_q   <= 5'd0;
			hold_q  <= '0;
			shift_q <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			shown_q <= '0;
		end else if (s_acc) begin
			step_q  <= step_n;
			sub_q   <= sub_n;
			hold_q  <= hold_n;
			shift_q <= shift_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			shown_q <= shown_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_acc) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			m_data_q <= {5'd0, shown_q.units, shown_q.tens, shown_q.hund, shown_q.sign,
				shown_q.valid, sda_n, scl_n};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire

// ----- sv/i2c_tsr_checker.sv -----
// Checker: port-level properties of the sensor reader, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module i2c_tsr_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [31:0] m_tdata
);

	// Stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result beat changed");

	// Take a tick whenever the result register frees up
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("slave ready does not follow result register");

	// Once a reading is shown it stays shown
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |=> !m_tvalid || m_tdata[2])
		else $error("reading valid dropped");

	// Sign is blank, plus or minus
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:3] == 6'd0 || m_tdata[8:3] == 6'd43
			|| m_tdata[8:3] == 6'd45))
		else $error("bad sign character");

	// No characters before the first reading
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[26:3] == 24'd0)
		else $error("characters shown before first reading");

endmodule

bind i2c_temp_sensor_reader_top i2c_tsr_checker u_i2c_tsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ----- tb/tb_i2c_temp_sensor_reader_top.sv -----
// Testbench: checks the sensor reader's pin levels and shown reading on every tick.
`timescale 1ns / 1ps
module tb_i2c_temp_sensor_reader_top;
	import i2c_tsr_pkg::*;

	localparam int HOLD = 1;
	localparam int LIMIT_CYCLES = 500000;
	localparam int RANDOM_TICKS = 50;
	localparam int RANDOM_CHUNKS = 5;
	// Register index 1 does not exist, so this address must be ignored
	localparam logic [2:0] BAD_REG_ADDR = 3'd4;
	localparam logic [2:0] SENSOR_ADDR_REG = {REG_SENSOR_ADDRESS, 2'b00};

	typedef struct {
		logic       scl;
		logic       sda;
		logic       valid;
		logic [5:0] sign;
		logic [5:0] hund;
		logic [5:0] tens;
		logic [5:0] units;
	} pin_beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predicted state of the pin program
	logic [2:0]  cfg_sensor_addr;
	int          prog_step;
	int          sub_step;
	int          hold_cnt;
	logic [2:0]  bit_cnt;
	logic [7:0]  shift_reg;
	logic        scl_drv;
	logic        sda_drv;
	logic        shown_valid;
	logic [5:0]  shown_sign;
	logic [5:0]  shown_hund;
	logic [5:0]  shown_tens;
	logic [5:0]  shown_units;

	pin_beat_t   pin_beats_due[$];
	int          fail_count;
	int          ticks_sent;
	int          readings_shown;
	int          reg_writes;
	int          cycle_count;
	bit          sender_idles;
	bit          receiver_stalls;

	i2c_temp_sensor_reader_top #(
		.HOLD_TICKS(HOLD)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("i2c_temp_sensor_reader_top regression: fail");
			$finish;
		end
	end

	// Mostly no gap, sometimes a short one, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void segment_at(input int step, output seg_kind_t kind,
			output byte_sel_t sel);
		sel = BYTE_ADDR_WR;
		case (step)
			0, 6, 12: kind = SEG_START;
			1, 7: kind = SEG_SEND;
			3: begin
				kind = SEG_SEND;
				sel = BYTE_CONVERT;
			end
			9: begin
				kind = SEG_SEND;
				sel = BYTE_FETCH;
			end
			13: begin
				kind = SEG_SEND;
				sel = BYTE_ADDR_RD;
			end
			2, 8, 14: kind = SEG_ACK;
			4, 10, 16: kind = SEG_NACK;
			15: kind = SEG_READ;
			default: kind = SEG_STOP;
		endcase
	endfunction

	function automatic int segment_ticks(input seg_kind_t kind);
		if (kind == SEG_START || kind == SEG_STOP)
			return 2;
		if (kind == SEG_ACK || kind == SEG_NACK)
			return 3;
		if (kind == SEG_SEND)
			return 17;
		return 16;
	endfunction

	function automatic logic [7:0] byte_to_send(input byte_sel_t sel);
		case (sel)
			BYTE_ADDR_WR: return ADDR_WR_BASE | {4'd0, cfg_sensor_addr, 1'b0};
			BYTE_ADDR_RD: return ADDR_RD_BASE | {4'd0, cfg_sensor_addr, 1'b0};
			BYTE_CONVERT: return CMD_CONVERT;
			default: return CMD_FETCH;
		endcase
	endfunction

	task automatic reset_model();
		cfg_sensor_addr = 3'd0;
		prog_step = 0;
		sub_step = 0;
		hold_cnt = 0;
		bit_cnt = 3'd0;
		shift_reg = 8'd0;
		scl_drv = 1'b1;
		sda_drv = 1'b1;
		shown_valid = 1'b0;
		shown_sign = 6'd0;
		shown_hund = 6'd0;
		shown_tens = 6'd0;
		shown_units = 6'd0;
	endtask

	// Format the byte read as sign and three ASCII digits
	task automatic show_temperature(input logic [7:0] d);
		logic [7:0] mag;
		if (d[7] && d != MOST_NEG) begin
			shown_sign = CHAR_MINUS;
			mag = -d;
		end else begin
			shown_sign = CHAR_PLUS;
			mag = d;
		end
		shown_hund = CHAR_ZERO + 6'(mag / 100);
		shown_tens = CHAR_ZERO + 6'((mag / 10) % 10);
		shown_units = CHAR_ZERO + 6'(mag % 10);
		shown_valid = 1'b1;
		readings_shown++;
	endtask

	// Advance the pin program by one tick and queue the beat it must produce
	task automatic advance_pin_program(input logic sda_in);
		seg_kind_t kind;
		byte_sel_t sel;
		pin_beat_t b;
		segment_at(prog_step, kind, sel);
		if (hold_cnt == 0) begin
			case (kind)
				SEG_START: begin
					scl_drv = 1'b1;
					sda_drv = (sub_step == 0);
				end
				SEG_STOP: begin
					scl_drv = 1'b1;
					sda_drv = (sub_step != 0);
				end
				SEG_ACK, SEG_NACK: begin
					sda_drv = (kind == SEG_NACK);
					if (sub_step == 1)
						scl_drv = 1'b1;
					else if (sub_step == 2)
						scl_drv = 1'b0;
				end
				SEG_SEND: begin
					if (sub_step == 0) begin
						shift_reg = byte_to_send(sel);
						bit_cnt = 3'd0;
					end
					if (sub_step >= 16) begin
						scl_drv = 1'b0;
					end else begin
						sda_drv = shift_reg[7];
						scl_drv = sub_step[0];
					end
				end
				default: begin
					if (sub_step == 0) begin
						shift_reg = 8'd0;
						bit_cnt = 3'd0;
					end
					sda_drv = 1'b1;
					scl_drv = sub_step[0];
				end
			endcase
		end
		b.scl = scl_drv;
		b.sda = sda_drv;
		b.valid = shown_valid;
		b.sign = shown_sign;
		b.hund = shown_hund;
		b.tens = shown_tens;
		b.units = shown_units;
		pin_beats_due.push_back(b);

		hold_cnt++;
		if (hold_cnt >= HOLD) begin
			hold_cnt = 0;
			// Shift on the clock-high half of each data bit
			if ((kind == SEG_SEND || kind == SEG_READ) && sub_step < 16 && sub_step[0]) begin
				shift_reg = (kind == SEG_READ) ? {shift_reg[6:0], sda_in}
					: {shift_reg[6:0], 1'b0};
				bit_cnt = bit_cnt + 3'd1;
			end
			sub_step++;
			if (sub_step >= segment_ticks(kind)) begin
				sub_step = 0;
				prog_step++;
				if (prog_step > LAST_STEP) begin
					show_temperature(shift_reg);
					prog_step = LOOP_STEP;
				end
			end
		end
	endtask

	// Data level to drive so that the sensor appears to return the given byte
	function automatic logic sda_for_reading(input logic [7:0] value);
		seg_kind_t kind;
		byte_sel_t sel;
		segment_at(prog_step, kind, sel);
		if (kind == SEG_READ && sub_step[0])
			return value[3'd7 - bit_cnt];
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic send_tick(input logic sda_in);
		int gap;
		gap = sender_idles ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {7'd0, sda_in};
		do @(posedge clk); while (!s_tready);
		advance_pin_program(sda_in);
		ticks_sent++;
	endtask

	// Hold ticks back until every predicted beat has been seen
	task automatic drain_block();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pin_beats_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[2] == REG_SENSOR_ADDRESS)
			cfg_sensor_addr = value[2:0];
		reg_writes++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Run ticks until the next reading is shown, steering the byte read
	task automatic run_reading(input logic [7:0] value);
		int seen;
		seen = readings_shown;
		while (readings_shown == seen)
			send_tick(sda_for_reading(value));
		// One more tick so the new reading appears on a beat
		send_tick(1'($urandom_range(0, 1)));
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each result beat against the oldest prediction
	always @(posedge clk) begin : check_beats
		pin_beat_t b;
		if (arst_n && m_tvalid && m_tready) begin
			if (pin_beats_due.size() == 0) begin
				$error("result beat with no tick pending: m_tdata %h", m_tdata);
				fail_count++;
			end else begin
				b = pin_beats_due.pop_front();
				check_field("scl_level", b.scl, m_tdata[0]);
				check_field("sda_level", b.sda, m_tdata[1]);
				check_field("temp_valid", b.valid, m_tdata[2]);
				check_field("sign_char", b.sign, m_tdata[8:3]);
				check_field("hundreds_char", b.hund, m_tdata[14:9]);
				check_field("tens_char", b.tens, m_tdata[20:15]);
				check_field("units_char", b.units, m_tdata[26:21]);
			end
		end
	end

	// Receiver back-pressure
	initial begin : drive_ready
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && receiver_stalls && arst_n)
				stall_left = pick_gap();
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Conversion start, then the first read with nothing shown before it
	task automatic test_power_up();
		run_reading(8'h00);
	endtask

	// Boundaries of the sign and digit formatting
	task automatic test_reading_extremes();
		logic [7:0] values[5];
		values = '{8'h7F, 8'h80, 8'h81, 8'hFF, 8'h9C};
		foreach (values[i])
			run_reading(values[i]);
	endtask

	// Address byte follows the register, upper write bits ignored
	task automatic test_address_settings();
		logic [2:0] addrs[1];
		addrs = '{3'd7};
		foreach (addrs[i]) begin
			drain_block();
			write_register(SENSOR_ADDR_REG, ($urandom() & 32'hFFFF_FFF8) | addrs[i]);
			run_reading(8'($urandom()));
		end
	endtask

	// Change the address while an address byte is half sent
	task automatic test_address_mid_byte();
		seg_kind_t kind;
		byte_sel_t sel;
		segment_at(prog_step, kind, sel);
		while (!(kind == SEG_SEND && (sel == BYTE_ADDR_WR || sel == BYTE_ADDR_RD)
				&& sub_step > 2 && sub_step < 14)) begin
			send_tick(1'($urandom_range(0, 1)));
			segment_at(prog_step, kind, sel);
		end
		drain_block();
		write_register(SENSOR_ADDR_REG, {29'd0, ~cfg_sensor_addr});
		run_reading(8'($urandom()));
	endtask

	// A write to a register that does not exist leaves the address alone
	task automatic test_bad_register();
		drain_block();
		write_register(BAD_REG_ADDR, {29'd0, ~cfg_sensor_addr});
		run_reading(8'($urandom()));
	endtask

	// Random data line with register changes and pauses between chunks
	task automatic test_random_ticks();
		for (int c = 0; c < RANDOM_CHUNKS; c++) begin
			drain_block();
			write_register(SENSOR_ADDR_REG, $urandom());
			sender_idles = (c != 1);
			receiver_stalls = (c != 1) && (c != 3);
			repeat (RANDOM_TICKS / RANDOM_CHUNKS)
				send_tick(1'($urandom_range(0, 1)));
		end
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'd0;
		fail_count = 0;
		ticks_sent = 0;
		readings_shown = 0;
		reg_writes = 0;
		cycle_count = 0;
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
		reset_model();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_power_up();
		test_reading_extremes();
		test_address_settings();
		test_address_mid_byte();
		test_bad_register();
		test_random_ticks();

		drain_block();
		repeat (10) @(posedge clk);
		if (pin_beats_due.size() != 0) begin
			$error("%0d result beats never arrived", pin_beats_due.size());
			fail_count++;
		end
		$display("covered %0d ticks, %0d readings shown, %0d register writes",
			ticks_sent, readings_shown, reg_writes);
		$display("with idle gaps, receiver stalls and address changes mid-byte");
		if (fail_count == 0)
			$display("i2c_temp_sensor_reader_top regression: pass");
		else
			$display("i2c_temp_sensor_reader_top regression: fail");
		$finish;
	end

endmodule
